### sv/bf2_pkg.sv
// Shared types and constants for the 2x2 box filter stream.
// No dependencies; used by bf2_ctrl, bf2_emit and the top level.
package bf2_pkg;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 11;
  localparam int CFG_W       = 12;
  localparam int MAX_WIDTH_DEF = 2048;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;
  localparam logic [CFG_W-1:0] MAX_HEIGHT   = 12'd2048;
  localparam logic [PIX_W+1:0] ROUND_BIAS   = 10'd2;

  // result slots of one input word, in emission order
  localparam int RES_FILT = 0;
  localparam int RES_PASS = 1;
  localparam int RES_LAST = 2;
  localparam int RES_N    = 3;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [RES_N-1:0]   mask;
  } item_t;

endpackage

### sv/box_filter_2x2_stream.sv
// 2x2 rounded box filter over a raster pixel stream, one line buffer.
// Accepted words sit in the working register; each result goes to a single output register.
// Throughput: one pixel per cycle while the output is not stalled and each pixel causes at
// most one result; a pixel with more holds the input until its last result is emitted.
// Reset (synchronous, rst_n low): counters to frame start, 640x480 geometry,
// pipeline empty; the line buffer is not cleared and needs no clearing pass.
module box_filter_2x2_stream #(
  parameter int MaxWidth = bf2_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [bf2_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bf2_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bf2_pkg::PIX_W-1:0]      out_pixel_out,
  output logic [bf2_pkg::COORD_W-1:0]    out_row,
  output logic [bf2_pkg::COORD_W-1:0]    out_col,
  output logic                           out_last_of_run
);

  localparam int CW = $clog2(MaxWidth);

  logic                        in_fire;
  logic [CW-1:0]               ram_addr;
  bf2_pkg::item_t              item;
  logic [bf2_pkg::PIX_W-1:0]   above;

  assign in_fire = in_valid && in_ready;

  bf2_ctrl #(.MaxWidth(MaxWidth)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .ram_addr  (ram_addr),
    .item      (item)
  );

  bf2_ram #(.Width(bf2_pkg::PIX_W), .Depth(MaxWidth)) u_line (
    .clk   (clk),
    .we    (in_fire),
    .waddr (ram_addr),
    .wdata (in_pixel_in),
    .re    (in_fire),
    .raddr (ram_addr),
    .rdata (above)
  );

  bf2_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .item_in   (item),
    .pix_in    (in_pixel_in),
    .above     (above),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel_out),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last_of_run)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=> out_valid)
    else $error("result run broken before its final word");

  a_run_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=>
      (out_row == $past(out_row)) || (out_row == $past(out_row) + 11'd1))
    else $error("row jump inside one result run");

endmodule

### sv/bf2_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write. No dependencies.
module bf2_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bf2_ctrl.sv
// Geometry registers, raster position counters and result-slot flags.
// Depends on bf2_pkg.
module bf2_ctrl #(
  parameter int MaxWidth = bf2_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [bf2_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_fire,
  output logic [$clog2(MaxWidth)-1:0]        ram_addr,
  output bf2_pkg::item_t                     item
);

  localparam int CW   = $clog2(MaxWidth);
  localparam int CMPW = (CW + 1 > bf2_pkg::CFG_W) ? CW + 1 : bf2_pkg::CFG_W;
  localparam int RW   = bf2_pkg::COORD_W;

  logic [bf2_pkg::CFG_W-1:0] width_r, height_r;
  logic [CW-1:0]             col_r, col_nxt;
  logic [RW-1:0]             row_r, row_nxt;

  logic [CMPW-1:0]           w_ext;
  logic [CMPW-1:0]           w_max;
  logic [CMPW-1:0]           wlast_ext;
  logic [CW-1:0]             wlast;
  logic [bf2_pkg::CFG_W-1:0] hlast_ext;
  logic [RW-1:0]             hlast;
  logic [CW+RW-1:0]          col_wide;

  assign w_ext = CMPW'(width_r);
  assign w_max = CMPW'(MaxWidth);

  always_comb begin
    priority if (w_ext == '0) begin
      wlast_ext = '0;
    end else if (w_ext > w_max) begin
      wlast_ext = w_max - CMPW'(1);
    end else begin
      wlast_ext = w_ext - CMPW'(1);
    end
    priority if (height_r == '0) begin
      hlast_ext = '0;
    end else if (height_r > bf2_pkg::MAX_HEIGHT) begin
      hlast_ext = bf2_pkg::MAX_HEIGHT - 12'd1;
    end else begin
      hlast_ext = height_r - 12'd1;
    end
  end

  assign wlast = wlast_ext[CW-1:0];
  assign hlast = hlast_ext[RW-1:0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (col_r == wlast) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bf2_pkg::RESET_WIDTH;
      height_r <= bf2_pkg::RESET_HEIGHT;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we) begin
        unique case (bf2_pkg::cfg_reg_t'(cfg_index))
          bf2_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          bf2_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign col_wide = {{RW{1'b0}}, col_r};
  assign ram_addr = col_r;

  always_comb begin
    item.row = row_r;
    item.col = col_wide[RW-1:0];
    item.mask[bf2_pkg::RES_FILT] = (row_r != '0) && (col_r != '0);
    item.mask[bf2_pkg::RES_PASS] = (row_r != '0) && (col_r == wlast);
    item.mask[bf2_pkg::RES_LAST] = (row_r == hlast);
  end

endmodule

### sv/bf2_emit.sv
// Working register, left-neighbor registers, 2x2 mean and result sequencing
// into the output register. Depends on bf2_pkg.
module bf2_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  bf2_pkg::item_t                item_in,
  input  logic [bf2_pkg::PIX_W-1:0]     pix_in,
  input  logic [bf2_pkg::PIX_W-1:0]     above,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bf2_pkg::PIX_W-1:0]     out_pixel,
  output logic [bf2_pkg::COORD_W-1:0]   out_row,
  output logic [bf2_pkg::COORD_W-1:0]   out_col,
  output logic                          out_last
);

  localparam int PW = bf2_pkg::PIX_W;
  localparam int RW = bf2_pkg::COORD_W;
  localparam int NR = bf2_pkg::RES_N;

  logic                a_valid_r;
  bf2_pkg::item_t      a_item_r;
  logic [PW-1:0]       a_pix_r;
  logic [PW-1:0]       left_cur_r, left_abv_r;

  logic                out_valid_r;
  logic [PW-1:0]       out_pixel_r;
  logic [RW-1:0]       out_row_r, out_col_r;
  logic                out_last_r;

  logic [PW+1:0]       sum;
  logic [NR-1:0]       pick;
  logic [PW-1:0]       sel_pix;
  logic [RW-1:0]       sel_row, sel_col;
  logic                one_left;
  logic                slot_free;
  logic                emit;
  logic                a_release;

  assign sum = (PW+2)'(left_abv_r) + (PW+2)'(above) + (PW+2)'(left_cur_r)
             + (PW+2)'(a_pix_r) + bf2_pkg::ROUND_BIAS;

  always_comb begin
    pick    = '0;
    sel_pix = a_pix_r;
    sel_row = a_item_r.row;
    sel_col = a_item_r.col;
    priority if (a_item_r.mask[bf2_pkg::RES_FILT]) begin
      pick[bf2_pkg::RES_FILT] = 1'b1;
      sel_pix = sum[PW+1:2];
      sel_row = a_item_r.row - RW'(1);
      sel_col = a_item_r.col - RW'(1);
    end else if (a_item_r.mask[bf2_pkg::RES_PASS]) begin
      pick[bf2_pkg::RES_PASS] = 1'b1;
      sel_pix = above;
      sel_row = a_item_r.row - RW'(1);
    end else if (a_item_r.mask[bf2_pkg::RES_LAST]) begin
      pick[bf2_pkg::RES_LAST] = 1'b1;
    end else begin
      pick = '0;
    end
  end

  assign one_left  = (a_item_r.mask & (a_item_r.mask - NR'(1))) == '0;
  assign slot_free = !out_valid_r || out_ready;
  assign emit      = a_valid_r && (a_item_r.mask != '0) && slot_free;
  assign a_release = a_valid_r && ((a_item_r.mask == '0) || (emit && one_left));
  assign in_ready  = !a_valid_r || a_release;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      left_cur_r  <= '0;
      left_abv_r  <= '0;
    end else begin
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (a_release) begin
        a_valid_r <= 1'b0;
      end
      if (a_release) begin
        left_cur_r <= a_pix_r;
        left_abv_r <= above;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item_r <= item_in;
      a_pix_r  <= pix_in;
    end else if (emit) begin
      a_item_r.mask <= a_item_r.mask & ~pick;
    end
    if (emit) begin
      out_pixel_r <= sel_pix;
      out_row_r   <= sel_row;
      out_col_r   <= sel_col;
      out_last_r  <= one_left;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

endmodule
